@@ design/rlst_pkg.sv @@
// Shared types, constants and token builder for the run-length segment tokenizer.
package rlst_pkg;

  // Longest segment held by the line store; the byte at LINE_MAX-1 closes it.
  localparam int unsigned LINE_MAX = 4096;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned VAL_W    = 8;
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(LINE_MAX - 1);
  localparam logic [CNT_W-1:0] SHORT_MAX = CNT_W'(256);

  // Burst queue between the detector and the token output.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_LITERAL = 1'b0,
    KIND_RUN     = 1'b1
  } tok_kind_e;

  typedef enum logic [2:0] {
    ST_DATA  = 3'b001,
    ST_RUN2  = 3'b010,
    ST_INRUN = 3'b100
  } det_state_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  start_offset;
    logic [VAL_W-1:0]  run_value;
    logic              long_form;
    logic              pad_needed;
  } token_t;

  // All tokens caused by one input byte: one or two, the last may close the segment.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
    logic   seg_done;
  } burst_t;

  function automatic token_t make_token(tok_kind_e kind, logic [CNT_W-1:0] count,
                                        logic [POS_W-1:0] start,
                                        logic [VAL_W-1:0] val);
    token_t t;
    t.kind         = kind;
    t.count        = count;
    t.start_offset = (kind == KIND_RUN) ? '0 : start;
    t.run_value    = (kind == KIND_RUN) ? val : '0;
    t.long_form    = (count > SHORT_MAX);
    t.pad_needed   = (kind == KIND_LITERAL) && count[0];
    return t;
  endfunction

endpackage

@@ design/rlst_front.sv @@
// Front end: run detector that turns each accepted byte into a burst of tokens.
module rlst_front import rlst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [VAL_W-1:0] value_i,
  input  logic             is_last_i,
  input  logic             full_i,
  output logic             push_o,
  output burst_t           burst_o
);

  det_state_e       st_q, st_d, st_n;
  logic             started_q, started_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] lit_q, lit_d, lit_n;
  logic [POS_W-1:0] cs_q, cs_d, cs_n;
  logic [VAL_W-1:0] cv_q, cv_d, cv_n;
  logic [POS_W-1:0] pos_cur;
  logic             accept;
  logic             last;
  logic             has_mid;
  token_t           mid_tok;
  token_t           end_tok;
  logic [CNT_W-1:0] end_len;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte against the current candidate run
  always_comb begin
    st_n    = st_q;
    lit_n   = lit_q;
    cs_n    = cs_q;
    cv_n    = cv_q;
    has_mid = 1'b0;
    mid_tok = make_token(KIND_LITERAL, '0, '0, '0);
    pos_cur = pos_q + POS_W'(1);
    if (!started_q) begin
      pos_cur = '0;
      st_n    = ST_DATA;
      lit_n   = '0;
      cs_n    = '0;
      cv_n    = value_i;
    end else begin
      case (st_q)
        ST_RUN2: begin
          if (value_i == cv_q) begin
            st_n = ST_INRUN;
            if (cs_q > lit_q) begin
              has_mid = 1'b1;
              mid_tok = make_token(KIND_LITERAL, {1'b0, cs_q - lit_q}, lit_q, '0);
            end
          end else begin
            st_n = ST_DATA;
            cv_n = value_i;
            cs_n = pos_cur;
          end
        end
        ST_INRUN: begin
          if (value_i != cv_q) begin
            has_mid = 1'b1;
            mid_tok = make_token(KIND_RUN, {1'b0, pos_cur - cs_q}, '0, cv_q);
            st_n    = ST_DATA;
            cv_n    = value_i;
            cs_n    = pos_cur;
            lit_n   = pos_cur;
          end
        end
        default: begin
          if (value_i == cv_q) begin
            st_n = ST_RUN2;
          end else begin
            st_n = ST_DATA;
            cv_n = value_i;
            cs_n = pos_cur;
          end
        end
      endcase
    end
  end

  // Close the segment on the flag or when the line store is full
  always_comb begin
    last = is_last_i || (pos_cur == LAST_POS);
    if (st_n == ST_INRUN) begin
      end_len = {1'b0, pos_cur} + CNT_W'(1) - {1'b0, cs_n};
      end_tok = make_token(KIND_RUN, end_len, '0, cv_n);
    end else begin
      end_len = {1'b0, pos_cur} + CNT_W'(1) - {1'b0, lit_n};
      end_tok = make_token(KIND_LITERAL, end_len, lit_n, '0);
    end
  end

  // Build the burst for the queue
  always_comb begin
    push_o           = accept && (has_mid || last);
    burst_o.tok0     = has_mid ? mid_tok : end_tok;
    burst_o.tok1     = end_tok;
    burst_o.two      = has_mid && last;
    burst_o.seg_done = last;
  end

  // Advance detector state, drop it all at segment end
  always_comb begin
    st_d      = st_q;
    started_d = started_q;
    pos_d     = pos_q;
    lit_d     = lit_q;
    cs_d      = cs_q;
    cv_d      = cv_q;
    if (accept) begin
      if (last) begin
        st_d      = ST_DATA;
        started_d = 1'b0;
        pos_d     = '0;
        lit_d     = '0;
        cs_d      = '0;
        cv_d      = '0;
      end else begin
        st_d      = st_n;
        started_d = 1'b1;
        pos_d     = pos_cur;
        lit_d     = lit_n;
        cs_d      = cs_n;
        cv_d      = cv_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_DATA;
      started_q <= 1'b0;
      pos_q     <= '0;
      lit_q     <= '0;
      cs_q      <= '0;
      cv_q      <= '0;
    end else begin
      st_q      <= st_d;
      started_q <= started_d;
      pos_q     <= pos_d;
      lit_q     <= lit_d;
      cs_q      <= cs_d;
      cv_q      <= cv_d;
    end
  end

`ifndef SYNTH
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last_i |=> !started_q)
    else $error("segment still open after final byte");

  a_forced_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (pos_q != LAST_POS))
    else $error("open segment reached the line store limit");
`endif

endmodule

@@ design/rlst_queue.sv @@
// Short burst queue that decouples the detector from the token output.
module rlst_queue import rlst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  burst_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output burst_t head_o
);

  burst_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the incoming burst
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("burst queue underflow");
`endif

endmodule

@@ design/rlst_back.sv @@
// Back end: splits bursts into tokens and holds them in the output register.
module rlst_back import rlst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  burst_t           head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [CNT_W-1:0] count_o,
  output logic [POS_W-1:0] start_offset_o,
  output logic [VAL_W-1:0] run_value_o,
  output logic             long_form_o,
  output logic             pad_needed_o,
  output logic             segment_done_o,
  output logic             burst_last_o
);

  logic   out_valid_q, out_valid_d;
  logic   sel_q, sel_d;
  logic   load;
  logic   last_of_burst;
  token_t cur;
  token_t tok_q;
  logic   seg_q;
  logic   blast_q;

  // Pick the next token of the head burst when the output register frees up
  always_comb begin
    load          = !empty_i && (!out_valid_q || out_ready_i);
    cur           = sel_q ? head_i.tok1 : head_i.tok0;
    last_of_burst = sel_q || !head_i.two;
    pop_o         = load && last_of_burst;
    sel_d         = load ? !last_of_burst : sel_q;
    out_valid_d   = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  // Hold the token payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q   <= cur;
      seg_q   <= last_of_burst && head_i.seg_done;
      blast_q <= last_of_burst;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = tok_q.kind;
  assign count_o        = tok_q.count;
  assign start_offset_o = tok_q.start_offset;
  assign run_value_o    = tok_q.run_value;
  assign long_form_o    = tok_q.long_form;
  assign pad_needed_o   = tok_q.pad_needed;
  assign segment_done_o = seg_q;
  assign burst_last_o   = blast_q;

`ifndef SYNTH
  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!empty_i && head_i.two))
    else $error("second token selected without a two-token burst");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && segment_done_o |-> burst_last_o)
    else $error("segment end token not last of its burst");
`endif

endmodule

@@ design/run_length_segment_tokenizer_top.sv @@
// Top level of the run-length segment tokenizer: detector, burst queue, token output.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o   value_i, is_last_i
//   out      source     out_valid_o/out_ready_i kind_o, count_o, start_offset_o, run_value_o,
//                                               long_form_o, pad_needed_o, segment_done_o,
//                                               burst_last_o
//
// One byte is taken per cycle unless the burst queue is full; the detector classifies it
// in the cycle it is taken. Tokens leave one per cycle from the output register while
// out_ready_i is high, so a byte that causes two tokens holds the output for both in turn;
// the four-entry burst queue absorbs this. in_ready_o drops only while that queue is full.
// After reset no segment is open and the block takes bytes at once; no clearing pass.
// The byte at offset 4095 closes its segment whatever is_last_i says.
module run_length_segment_tokenizer_top import rlst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [VAL_W-1:0] value_i,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [CNT_W-1:0] count_o,
  output logic [POS_W-1:0] start_offset_o,
  output logic [VAL_W-1:0] run_value_o,
  output logic             long_form_o,
  output logic             pad_needed_o,
  output logic             segment_done_o,
  output logic             burst_last_o
);

  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  burst_t burst;
  burst_t head;

  rlst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .is_last_i  (is_last_i),
    .full_i     (full),
    .push_o     (push),
    .burst_o    (burst)
  );

  rlst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (burst),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  rlst_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .count_o        (count_o),
    .start_offset_o (start_offset_o),
    .run_value_o    (run_value_o),
    .long_form_o    (long_form_o),
    .pad_needed_o   (pad_needed_o),
    .segment_done_o (segment_done_o),
    .burst_last_o   (burst_last_o)
  );

endmodule

@@ tb/sv/tb_run_length_segment_tokenizer_top.sv @@
// Self-checking testbench for the run-length segment tokenizer top level.
module tb_run_length_segment_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlst_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RAND_ITEMS   = 400;
  localparam int unsigned PRINT_MAX    = 40;

  // One expected or observed token with all of its side flags.
  typedef struct {
    tok_kind_e        kind;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] start_offset;
    logic [VAL_W-1:0] run_value;
    logic             long_form;
    logic             pad_needed;
    logic             segment_done;
    logic             burst_last;
  } token_rec_t;

  // Tracks the segment tokenizer state and holds the tokens still owed by the block.
  class token_scoreboard;
    token_rec_t       owed_q[$];
    int unsigned      errors;
    int unsigned      checked;
    det_state_e       det;
    bit               seg_open;
    int unsigned      pos;
    int unsigned      lit_start;
    int unsigned      cand_start;
    logic [VAL_W-1:0] cand_val;

    function new();
      errors  = 0;
      checked = 0;
      close_segment();
    endfunction

    function void close_segment();
      det        = ST_DATA;
      seg_open   = 1'b0;
      pos        = 0;
      lit_start  = 0;
      cand_start = 0;
      cand_val   = '0;
    endfunction

    function token_rec_t build(tok_kind_e kind, int unsigned cnt, int unsigned start,
                               logic [VAL_W-1:0] val);
      token_rec_t t;
      t.kind         = kind;
      t.count        = CNT_W'(cnt);
      t.start_offset = (kind == KIND_RUN) ? '0 : POS_W'(start);
      t.run_value    = (kind == KIND_RUN) ? val : '0;
      t.long_form    = (cnt - 1 > 255);
      t.pad_needed   = (kind == KIND_LITERAL) && cnt[0];
      t.segment_done = 1'b0;
      t.burst_last   = 1'b0;
      return t;
    endfunction

    // Advance the detector by one accepted request and queue the tokens it causes.
    function void note_request(logic [VAL_W-1:0] v, bit last);
      int unsigned p;
      token_rec_t  burst[$];
      token_rec_t  t;
      if (!seg_open) begin
        p          = 0;
        seg_open   = 1'b1;
        det        = ST_DATA;
        lit_start  = 0;
        cand_start = 0;
        cand_val   = v;
      end else begin
        p = pos + 1;
        case (det)
          ST_RUN2: begin
            if (v == cand_val) begin
              det = ST_INRUN;
              // Flush pending literal bytes only if there are any.
              if (cand_start > lit_start)
                burst.push_back(build(KIND_LITERAL, cand_start - lit_start, lit_start, '0));
            end else begin
              det        = ST_DATA;
              cand_val   = v;
              cand_start = p;
            end
          end
          ST_INRUN: begin
            if (v != cand_val) begin
              burst.push_back(build(KIND_RUN, p - cand_start, 0, cand_val));
              det        = ST_DATA;
              cand_val   = v;
              cand_start = p;
              lit_start  = p;
            end
          end
          default: begin
            if (v == cand_val) begin
              det = ST_RUN2;
            end else begin
              det        = ST_DATA;
              cand_val   = v;
              cand_start = p;
            end
          end
        endcase
      end
      pos = p;

      // The byte at the end of the line store closes the segment regardless of the flag.
      if (p >= LINE_MAX - 1)
        last = 1'b1;

      if (last) begin
        if (det == ST_INRUN)
          t = build(KIND_RUN, p + 1 - cand_start, 0, cand_val);
        else
          t = build(KIND_LITERAL, p + 1 - lit_start, lit_start, '0);
        t.segment_done = 1'b1;
        burst.push_back(t);
        close_segment();
      end

      if (burst.size() > 0)
        burst[burst.size()-1].burst_last = 1'b1;
      foreach (burst[i])
        owed_q.push_back(burst[i]);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      if (errors < PRINT_MAX)
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Unknown bits count as a mismatch.
    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("token %0d %s got %0d want %0d", checked, name, got, want));
    endtask

    // Compare one accepted token with the oldest owed one.
    task check_token(token_rec_t got);
      token_rec_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("token %0d arrived with nothing owed (kind %0d count %0d)",
                         checked, got.kind, got.count));
      end else begin
        want = owed_q.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("count", got.count, want.count);
        check_field("start_offset", got.start_offset, want.start_offset);
        check_field("run_value", got.run_value, want.run_value);
        check_field("long_form", got.long_form, want.long_form);
        check_field("pad_needed", got.pad_needed, want.pad_needed);
        check_field("segment_done", got.segment_done, want.segment_done);
        check_field("burst_last", got.burst_last, want.burst_last);
      end
      checked++;
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic [VAL_W-1:0] value_i        = '0;
  logic             is_last_i      = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic             kind_o;
  logic [CNT_W-1:0] count_o;
  logic [POS_W-1:0] start_offset_o;
  logic [VAL_W-1:0] run_value_o;
  logic             long_form_o;
  logic             pad_needed_o;
  logic             segment_done_o;
  logic             burst_last_o;

  token_scoreboard  sb = new();
  bit               quiet = 1'b0;
  int unsigned      cycle_count = 0;
  logic [VAL_W-1:0] seg_q[$];

  run_length_segment_tokenizer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .count_o        (count_o),
    .start_offset_o (start_offset_o),
    .run_value_o    (run_value_o),
    .long_form_o    (long_form_o),
    .pad_needed_o   (pad_needed_o),
    .segment_done_o (segment_done_o),
    .burst_last_o   (burst_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Give up on a hung run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run_length_segment_tokenizer_top verification failed");
    $finish;
  end

  // Mostly no gap, some short gaps, a few long ones; none during quiet stretches.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet)
      return 0;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Present one byte request after a random gap and hold it until accepted.
  task send_byte(input logic [VAL_W-1:0] v, input bit last);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(v, last);
  endtask

  // Send seg_q as one segment, flag on its final byte.
  task send_seg();
    foreach (seg_q[i])
      send_byte(seg_q[i], i == seg_q.size() - 1);
  endtask

  // Fill a whole line; flat lines hold one value, others random bytes.
  task send_full_line(input bit flat, input bit flag_end);
    for (int unsigned i = 0; i < LINE_MAX; i++)
      send_byte(flat ? 8'h3C : VAL_W'($urandom_range(255)), flag_end && (i == LINE_MAX - 1));
  endtask

  // Accept tokens with random stalls and check each one.
  initial begin : token_sink
    token_rec_t  got;
    int unsigned stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.kind         = tok_kind_e'(kind_o);
        got.count        = count_o;
        got.start_offset = start_offset_o;
        got.run_value    = run_value_o;
        got.long_form    = long_form_o;
        got.pad_needed   = pad_needed_o;
        got.segment_done = segment_done_o;
        got.burst_last   = burst_last_o;
        sb.check_token(got);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = idle_len();
      end
    end
  end

  initial begin : stimulus
    int unsigned      rand_items;
    int unsigned      nruns;
    int unsigned      len;
    int unsigned      k;
    logic [VAL_W-1:0] prev;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single byte segments at both value extremes.
    seg_q = '{8'h00};
    send_seg();
    seg_q = '{8'hFF};
    send_seg();
    // Run confirmed with no literal bytes pending, closed while in the run.
    seg_q = '{8'hA5, 8'hA5, 8'hA5};
    send_seg();
    // Literal, run, broken run, trailing literal; the last two tokens share one burst.
    seg_q = '{8'h01, 8'h02, 8'h07, 8'h07, 8'h07, 8'h09};
    send_seg();
    // Two equal bytes at the end stay literal.
    seg_q = '{8'h10, 8'h20, 8'h20};
    send_seg();
    // Last byte confirms a run: literal and run tokens from one request.
    seg_q = '{8'h01, 8'hFF, 8'hFF, 8'hFF};
    send_seg();

    // Long literal segment to reach the long form.
    seg_q.delete();
    for (int unsigned i = 0; i < 300; i++)
      seg_q.push_back(VAL_W'(i));
    send_seg();

    // Forced segment end at the line store limit.
    send_full_line(1'b1, 1'b0);
    send_full_line(1'b0, 1'b1);

    // Random segments built from runs of random lengths and values.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      quiet = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) begin
        // Loose bytes with a random end flag.
        len = $urandom_range(1, 12);
        repeat (len) begin
          send_byte(VAL_W'($urandom_range(255)), $urandom_range(7) == 0);
          rand_items++;
        end
      end else begin
        nruns = $urandom_range(1, 6);
        prev  = VAL_W'($urandom_range(255));
        for (int unsigned r = 0; r < nruns; r++) begin
          // Sometimes repeat the previous value so neighboring runs merge.
          if ($urandom_range(4) != 0)
            prev = VAL_W'($urandom_range(255));
          k = $urandom_range(99);
          if (k < 60)
            len = $urandom_range(1, 2);
          else if (k < 96)
            len = $urandom_range(3, 8);
          else
            len = $urandom_range(9, 300);
          for (int unsigned j = 0; j < len; j++) begin
            send_byte(prev, (r == nruns - 1) && (j == len - 1));
            rand_items++;
          end
        end
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // Drain owed tokens, then watch for strays.
    while (sb.pending() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0)
      $display("run_length_segment_tokenizer_top verification clean");
    else
      $display("run_length_segment_tokenizer_top verification failed");
    $finish;
  end

endmodule

@@ files.f @@
design/rlst_pkg.sv
design/rlst_front.sv
design/rlst_queue.sv
design/rlst_back.sv
design/run_length_segment_tokenizer_top.sv
tb/sv/tb_run_length_segment_tokenizer_top.sv
